/* src/sliding_window_key_admission_macros.svh */
// Assertion macros shared by the checker files of the admission limiter.
// Each one samples on the rising edge of clk and is off while rst_n is low.
`ifndef SLIDING_WINDOW_KEY_ADMISSION_MACROS_SVH
`define SLIDING_WINDOW_KEY_ADMISSION_MACROS_SVH

// Same-cycle implication.
`define SWKA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sliding window admission: check failed");

// Next-cycle implication.
`define SWKA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sliding window admission: check failed");

`endif

/* src/swka_pkg.sv */
// ----------------------------------------------------------------------------
// swka_pkg
// Shared constants, register indexes and types of the sliding window
// per-key admission limiter.
// ----------------------------------------------------------------------------
`default_nettype none

package swka_pkg;

    localparam int WINDOW_MAX = 1024;
    localparam int KEY_COUNT  = 1024;

    localparam int KEY_W     = 10;
    localparam int CFG_W     = 11;
    localparam int CNT_W     = 11;
    localparam int TOTAL_W   = 24;
    localparam int CFG_IDX_W = 1;

    localparam int SLOT_W    = $clog2(WINDOW_MAX);
    localparam int KEY_IDX_W = $clog2(KEY_COUNT);
    localparam int ARR_W     = $clog2(WINDOW_MAX + 1);

    localparam logic [CNT_W-1:0]   CNT_TOP   = {CNT_W{1'b1}};
    localparam logic [TOTAL_W-1:0] TOTAL_TOP = {TOTAL_W{1'b1}};

    localparam logic [CFG_W-1:0] WINDOW_RESET = CFG_W'(16);
    localparam logic [CFG_W-1:0] KEEP_RESET   = CFG_W'(1);

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_KEEP_LIMIT    = CFG_IDX_W'(1);

    // output queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [KEY_IDX_W-1:0] key;
        logic                 kept;
    } ring_ent_t;

    typedef struct packed {
        logic               discarded;
        logic [TOTAL_W-1:0] total;
    } result_t;

endpackage

`default_nettype wire

/* src/swka_ram.sv */
// ----------------------------------------------------------------------------
// swka_ram
// Simple dual-port synchronous RAM: one write port, one read port,
// registered read data (read-during-write returns the old word).
// ----------------------------------------------------------------------------
`default_nettype none

module swka_ram #(
    parameter int  DEPTH = 1024,
    parameter int  WIDTH = 8,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

/* src/swka_out_fifo.sv */
// ----------------------------------------------------------------------------
// swka_out_fifo
// Small result queue between the compute stage and the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module swka_out_fifo (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire swka_pkg::result_t push_data,
    input  wire logic              pop,
    output logic                   valid,
    output swka_pkg::result_t      head
);

    import swka_pkg::*;

    result_t                entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  wr_ptr_reg;
    logic [FIFO_PTR_W-1:0]  rd_ptr_reg;
    logic [FIFO_CNT_W-1:0]  count_reg;

    assign valid = (count_reg != '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + FIFO_CNT_W'(1);
                2'b01:   count_reg <= count_reg - FIFO_CNT_W'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

/* src/sliding_window_key_admission.sv */
// ----------------------------------------------------------------------------
// sliding_window_key_admission
// Per-key sliding-window admission limiter with ring and count table in RAM.
// ----------------------------------------------------------------------------
// Takes arrival keys, though not while the last key is still in stage 1,
// and returns one result beat per key (discarded flag, saturating discard
// total), pushed from stage 3 into a 4-deep result queue so the input keeps
// moving while the result side stalls, until four accepted beats wait. The
// gap between keys comes from the key count table: one read port and one
// write port, two read-modify-writes per arrival (the key leaving the window
// and the new key). After reset a clearing pass zeroes the 1024 count table
// entries, item_stall high; configuration writes are taken at any time.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_key_admission (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           item_valid,
    output logic                                item_stall,
    input  wire logic [swka_pkg::KEY_W-1:0]     item_key,
    output logic                                result_valid,
    input  wire logic                           result_stall,
    output logic                                discarded,
    output logic      [swka_pkg::TOTAL_W-1:0]   discard_total,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [swka_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [swka_pkg::CFG_W-1:0]     cfg_data
);

    import swka_pkg::*;

    typedef struct packed {
        logic                 valid;
        logic [KEY_IDX_W-1:0] key;
        logic [CNT_W-1:0]     value;
    } cnt_fwd_t;

    typedef struct packed {
        logic              valid;
        logic [SLOT_W-1:0] slot;
        ring_ent_t         ent;
    } ring_fwd_t;

    function automatic logic [CNT_W-1:0] count_pick(
        input logic [KEY_IDX_W-1:0] key,
        input logic [CNT_W-1:0]     raw,
        input cnt_fwd_t             newer,
        input cnt_fwd_t             older
    );
        logic [CNT_W-1:0] v;
        v = raw;
        if (newer.valid && newer.key == key)
        begin
            v = newer.value;
        end
        else if (older.valid && older.key == key)
        begin
            v = older.value;
        end
        return v;
    endfunction

    // configuration
    logic [CFG_W-1:0]     window_length_reg;
    logic [CFG_W-1:0]     keep_limit_reg;

    // arrival bookkeeping
    logic [ARR_W-1:0]     arr_cnt_reg;
    logic [SLOT_W-1:0]    write_slot_reg;
    logic [TOTAL_W-1:0]   discard_sum_reg;
    logic [TOTAL_W-1:0]   discard_sum_next;

    // clearing pass
    logic                 clear_busy_reg;
    logic [KEY_IDX_W-1:0] clear_addr_reg;

    // beats accepted whose result has not left the queue
    logic [FIFO_CNT_W-1:0] reserved_reg;

    logic                 in_accept;
    logic                 out_pop;
    logic [ARR_W-1:0]     span;
    logic                 evict_now;
    logic [SLOT_W-1:0]    old_slot_now;

    // pipeline stages
    logic                 s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg;
    logic [KEY_IDX_W-1:0] s1_key_reg, s2_key_reg, s3_key_reg, s4_key_reg;
    logic [SLOT_W-1:0]    s1_slot_reg, s2_slot_reg, s3_slot_reg, s4_slot_reg;
    logic [SLOT_W-1:0]    s1_old_reg, s2_old_reg, s3_old_reg;
    logic                 s1_evict_reg, s2_evict_reg, s3_evict_reg;
    logic [KEY_IDX_W-1:0] s3_old_key_reg;
    logic                 s3_old_kept_reg;
    logic [CNT_W-1:0]     s3_cnt_new_reg;
    logic                 s4_kept_reg;
    logic [CNT_W-1:0]     s4_cnt_reg;

    // forwarding of the last item's writes
    cnt_fwd_t             fwd_new_reg, fwd_old_reg;
    ring_fwd_t            fwd_ent_reg, fwd_clr_reg;
    cnt_fwd_t             fwd_new_next, fwd_old_next;

    // memories
    logic                 ring_wr_en;
    logic [SLOT_W-1:0]    ring_wr_addr;
    ring_ent_t            ring_wr_data;
    ring_ent_t            ring_rd_data;
    ring_ent_t            old_ent;

    logic                 cnt_wr_en;
    logic [KEY_IDX_W-1:0] cnt_wr_addr;
    logic [CNT_W-1:0]     cnt_wr_data;
    logic [KEY_IDX_W-1:0] cnt_rd_addr;
    logic [CNT_W-1:0]     cnt_rd_data;

    // compute stage
    logic                 dec;
    logic                 split_write;
    logic [CNT_W-1:0]     c_old;
    logic [CNT_W-1:0]     c_old_dec;
    logic [CNT_W-1:0]     c_new0;
    logic [CNT_W-1:0]     c_new1;
    logic                 drop;

    result_t              push_data;
    result_t              head;
    logic                 q_valid;

    // ---------------------------------------------------------------- input side
    assign item_stall = clear_busy_reg || s1_v_reg
                        || (reserved_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign in_accept  = item_valid && !item_stall;
    assign cfg_ready  = 1'b1;

    always_comb
    begin
        if (window_length_reg == '0)
        begin
            span = ARR_W'(1);
        end
        else if (window_length_reg > CFG_W'(WINDOW_MAX))
        begin
            span = ARR_W'(WINDOW_MAX);
        end
        else
        begin
            span = ARR_W'(window_length_reg);
        end
    end

    assign evict_now    = (arr_cnt_reg >= span);
    assign old_slot_now = write_slot_reg - span[SLOT_W-1:0];

    // ---------------------------------------------------------------- memories
    swka_ram #(
        .DEPTH (WINDOW_MAX),
        .WIDTH ($bits(ring_ent_t))
    ) u_ring (
        .clk     (clk),
        .wr_en   (ring_wr_en),
        .wr_addr (ring_wr_addr),
        .wr_data (ring_wr_data),
        .rd_addr (s1_old_reg),
        .rd_data (ring_rd_data)
    );

    swka_ram #(
        .DEPTH (KEY_COUNT),
        .WIDTH (CNT_W)
    ) u_count (
        .clk     (clk),
        .wr_en   (cnt_wr_en),
        .wr_addr (cnt_wr_addr),
        .wr_data (cnt_wr_data),
        .rd_addr (cnt_rd_addr),
        .rd_data (cnt_rd_data)
    );

    // stage 2: leaving slot, patched with the last item's ring writes
    always_comb
    begin
        old_ent = ring_rd_data;
        if (fwd_ent_reg.valid && fwd_ent_reg.slot == s2_old_reg)
        begin
            old_ent = fwd_ent_reg.ent;
        end
        else if (fwd_clr_reg.valid && fwd_clr_reg.slot == s2_old_reg)
        begin
            old_ent.kept = 1'b0;
        end
    end

    // new key is read in stage 1, leaving key in stage 2; never both at once
    assign cnt_rd_addr = s2_v_reg ? old_ent.key : s1_key_reg;

    // ---------------------------------------------------------------- stage 3
    always_comb
    begin
        dec         = s3_evict_reg && s3_old_kept_reg;
        split_write = dec && (s3_old_key_reg != s3_key_reg);
        c_old       = count_pick(s3_old_key_reg, cnt_rd_data, fwd_new_reg, fwd_old_reg);
        c_old_dec   = (c_old != '0) ? c_old - CNT_W'(1) : c_old;
        c_new0      = count_pick(s3_key_reg, s3_cnt_new_reg, fwd_new_reg, fwd_old_reg);
        if (dec && !split_write)
        begin
            c_new0 = c_old_dec;
        end
        drop   = (c_new0 >= keep_limit_reg);
        c_new1 = (!drop && c_new0 != CNT_TOP) ? c_new0 + CNT_W'(1) : c_new0;

        discard_sum_next = discard_sum_reg;
        if (drop && discard_sum_reg != TOTAL_TOP)
        begin
            discard_sum_next = discard_sum_reg + TOTAL_W'(1);
        end

        fwd_new_next.valid = 1'b1;
        fwd_new_next.key   = s3_key_reg;
        fwd_new_next.value = c_new1;
        fwd_old_next.valid = split_write;
        fwd_old_next.key   = s3_old_key_reg;
        fwd_old_next.value = c_old_dec;
    end

    // count table writes: clear pass, then leaving key (stage 3), new key (stage 4)
    always_comb
    begin
        cnt_wr_en   = 1'b0;
        cnt_wr_addr = s4_key_reg;
        cnt_wr_data = s4_cnt_reg;
        if (clear_busy_reg)
        begin
            cnt_wr_en   = 1'b1;
            cnt_wr_addr = clear_addr_reg;
            cnt_wr_data = '0;
        end
        else if (s3_v_reg && split_write)
        begin
            cnt_wr_en   = 1'b1;
            cnt_wr_addr = s3_old_key_reg;
            cnt_wr_data = c_old_dec;
        end
        else if (s4_v_reg)
        begin
            cnt_wr_en = 1'b1;
        end
    end

    // ring writes: drop kept flag of leaving slot (stage 3), new entry (stage 4)
    always_comb
    begin
        ring_wr_en        = 1'b0;
        ring_wr_addr      = s4_slot_reg;
        ring_wr_data.key  = s4_key_reg;
        ring_wr_data.kept = s4_kept_reg;
        if (s3_v_reg && dec)
        begin
            ring_wr_en        = 1'b1;
            ring_wr_addr      = s3_old_reg;
            ring_wr_data.key  = s3_old_key_reg;
            ring_wr_data.kept = 1'b0;
        end
        else if (s4_v_reg)
        begin
            ring_wr_en = 1'b1;
        end
    end

    // ---------------------------------------------------------------- results
    assign push_data.discarded = drop;
    assign push_data.total     = discard_sum_next;

    swka_out_fifo u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s3_v_reg),
        .push_data (push_data),
        .pop       (out_pop),
        .valid     (q_valid),
        .head      (head)
    );

    assign result_valid  = q_valid;
    assign out_pop       = q_valid && !result_stall;
    assign discarded     = head.discarded;
    assign discard_total = head.total;

    // ---------------------------------------------------------------- registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg <= WINDOW_RESET;
            keep_limit_reg    <= KEEP_RESET;
            arr_cnt_reg       <= '0;
            write_slot_reg    <= '0;
            discard_sum_reg   <= '0;
            clear_busy_reg    <= 1'b1;
            clear_addr_reg    <= '0;
            reserved_reg      <= '0;
            s1_v_reg          <= 1'b0;
            s2_v_reg          <= 1'b0;
            s3_v_reg          <= 1'b0;
            s4_v_reg          <= 1'b0;
            fwd_new_reg       <= '0;
            fwd_old_reg       <= '0;
            fwd_ent_reg       <= '0;
            fwd_clr_reg       <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_WINDOW_LENGTH: window_length_reg <= cfg_data;
                    REG_KEEP_LIMIT:    keep_limit_reg    <= cfg_data;
                    default:           ;
                endcase
            end

            if (clear_busy_reg)
            begin
                clear_addr_reg <= clear_addr_reg + KEY_IDX_W'(1);
                if (clear_addr_reg == KEY_IDX_W'(KEY_COUNT - 1))
                begin
                    clear_busy_reg <= 1'b0;
                end
            end

            case ({in_accept, out_pop})
                2'b10:   reserved_reg <= reserved_reg + FIFO_CNT_W'(1);
                2'b01:   reserved_reg <= reserved_reg - FIFO_CNT_W'(1);
                default: reserved_reg <= reserved_reg;
            endcase

            if (in_accept)
            begin
                write_slot_reg <= write_slot_reg + SLOT_W'(1);
                if (arr_cnt_reg != ARR_W'(WINDOW_MAX))
                begin
                    arr_cnt_reg <= arr_cnt_reg + ARR_W'(1);
                end
            end

            s1_v_reg <= in_accept;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
            s4_v_reg <= s3_v_reg;

            if (s3_v_reg)
            begin
                discard_sum_reg      <= discard_sum_next;
                fwd_new_reg          <= fwd_new_next;
                fwd_old_reg          <= fwd_old_next;
                fwd_ent_reg.valid    <= 1'b1;
                fwd_ent_reg.slot     <= s3_slot_reg;
                fwd_ent_reg.ent.key  <= s3_key_reg;
                fwd_ent_reg.ent.kept <= !drop;
                fwd_clr_reg.valid    <= dec;
                fwd_clr_reg.slot     <= s3_old_reg;
                fwd_clr_reg.ent.key  <= s3_old_key_reg;
                fwd_clr_reg.ent.kept <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_key_reg   <= item_key[KEY_IDX_W-1:0];
            s1_slot_reg  <= write_slot_reg;
            s1_old_reg   <= old_slot_now;
            s1_evict_reg <= evict_now;
        end

        s2_key_reg   <= s1_key_reg;
        s2_slot_reg  <= s1_slot_reg;
        s2_old_reg   <= s1_old_reg;
        s2_evict_reg <= s1_evict_reg;

        s3_key_reg      <= s2_key_reg;
        s3_slot_reg     <= s2_slot_reg;
        s3_old_reg      <= s2_old_reg;
        s3_evict_reg    <= s2_evict_reg;
        s3_old_key_reg  <= old_ent.key;
        s3_old_kept_reg <= old_ent.kept;
        s3_cnt_new_reg  <= cnt_rd_data;

        s4_key_reg  <= s3_key_reg;
        s4_slot_reg <= s3_slot_reg;
        s4_kept_reg <= !drop;
        s4_cnt_reg  <= c_new1;
    end

endmodule

`default_nettype wire

/* src/swka_checker.sv */
// ----------------------------------------------------------------------------
// swka_checker
// Port-level checks on the admission limiter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sliding_window_key_admission_macros.svh"

module swka_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           item_stall,
    input wire logic                           result_valid,
    input wire logic                           result_stall,
    input wire logic                           discarded,
    input wire logic [swka_pkg::TOTAL_W-1:0]   discard_total
);

    // a stalled result beat stays up and keeps its payload
    `SWKA_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid)
    `SWKA_ASSERT_NEXT(a_payload_hold, result_valid && result_stall, $stable(discarded) && $stable(discard_total))

    // count table is being cleared right after reset: no beats either way
    `SWKA_ASSERT_NOW(a_clear_after_reset, !$past(rst_n), item_stall && !result_valid)

    // a discarded beat is already included in the total
    `SWKA_ASSERT_NOW(a_discard_counted, result_valid && discarded, discard_total != '0)

endmodule

bind sliding_window_key_admission swka_checker u_swka_checker (.*);

`default_nettype wire
